// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define BB3_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define BB3_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bb3_pkg.sv =====
package bb3_pkg;

    localparam int MaxWidthDef = 1024;
    localparam int FwW         = 11;
    localparam int FhW         = 13;
    localparam int CfgW        = 13;
    localparam int RowW        = FhW + 1;
    localparam int ChW         = 8;
    localparam int PixW        = 3 * ChW;
    localparam int SumW        = 12;

    localparam logic [FwW-1:0] FwReset = 11'd640;
    localparam logic [FhW-1:0] FhReset = 13'd480;

    // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
    localparam int               DivMulW  = 13;
    localparam logic [DivMulW-1:0] DivMul = 13'd7282;
    localparam int               DivShift = 16;

    localparam int OutDepth = 8;
    localparam int PtrW     = $clog2(OutDepth);
    localparam int OccW     = PtrW + 1;

    typedef enum logic {
        CfgFrameWidth  = 1'b0,
        CfgFrameHeight = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } t_tag;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_inflight;

    typedef struct packed {
        logic            last;
        logic [PixW-1:0] pix;
    } t_result;

endpackage

// ===== hw/rtl/bb3_ctrl.sv =====
module bb3_ctrl #(
    parameter int MAX_WIDTH = bb3_pkg::MaxWidthDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  bb3_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [bb3_pkg::CfgW-1:0]  i_cfg_data,
    input  logic                      i_acc,
    input  logic                      i_cmd,
    input  logic [bb3_pkg::PixW-1:0]  i_pix,
    output logic                      o_v,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col,
    output logic [bb3_pkg::PixW-1:0]  o_pix,
    output bb3_pkg::t_tag             o_tag
);

    localparam int ColW = $clog2(MAX_WIDTH);
    localparam int WW   = ColW + 1;

    logic [bb3_pkg::FwW-1:0]  r_fw;
    logic [bb3_pkg::FhW-1:0]  r_fh;
    logic [ColW-1:0]          r_in_col;
    logic [bb3_pkg::RowW-1:0] r_in_row;
    logic [ColW-1:0]          r_out_col;
    logic [bb3_pkg::FhW-1:0]  r_out_row;

    logic [WW-1:0]            w;
    logic [bb3_pkg::FhW-1:0]  h;
    logic                     draining;
    logic                     ignore;
    logic                     emit;
    logic                     interior;
    logic                     last;
    logic [WW-1:0]            in_col_p1;
    logic [WW-1:0]            out_col_p1;
    logic [bb3_pkg::RowW-1:0] out_row_x;

    always_comb begin
        if (r_fw == '0) begin
            w = WW'(1);
        end else if (32'(r_fw) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_fw);
        end
        h = (r_fh == '0) ? bb3_pkg::FhW'(1) : r_fh;

        draining   = r_in_row >= {1'b0, h};
        ignore     = !draining && i_cmd;
        emit       = (r_in_row >= bb3_pkg::RowW'(2))
                     || (r_in_row == bb3_pkg::RowW'(1) && r_in_col != '0);
        in_col_p1  = {1'b0, r_in_col} + WW'(1);
        out_col_p1 = {1'b0, r_out_col} + WW'(1);
        out_row_x  = {1'b0, r_out_row};
        interior   = (r_out_row != '0)
                     && (out_row_x + bb3_pkg::RowW'(2) <= {1'b0, h})
                     && (r_out_col != '0)
                     && (out_col_p1 + WW'(1) <= w);
        last       = (out_row_x + bb3_pkg::RowW'(1) >= {1'b0, h}) && (out_col_p1 >= w);
    end

    assign o_v          = i_acc && !ignore;
    assign o_col        = r_in_col;
    assign o_pix        = draining ? '0 : i_pix;
    assign o_tag.emit     = emit;
    assign o_tag.interior = interior;
    assign o_tag.last     = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw      <= bb3_pkg::FwReset;
            r_fh      <= bb3_pkg::FhReset;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bb3_pkg::CfgFrameWidth:  r_fw <= i_cfg_data[bb3_pkg::FwW-1:0];
                bb3_pkg::CfgFrameHeight: r_fh <= i_cfg_data[bb3_pkg::FhW-1:0];
            endcase
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (o_v) begin
            if (emit && last) begin
                // frame done: start over
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (in_col_p1 >= w) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + bb3_pkg::RowW'(1);
                end else begin
                    r_in_col <= in_col_p1[ColW-1:0];
                end
                if (emit) begin
                    if (out_col_p1 >= w) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + bb3_pkg::FhW'(1);
                    end else begin
                        r_out_col <= out_col_p1[ColW-1:0];
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/bb3_window.sv =====
module bb3_window #(
    parameter int MAX_WIDTH = bb3_pkg::MaxWidthDef
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_v,
    input  logic [$clog2(MAX_WIDTH)-1:0]           i_col,
    input  logic [bb3_pkg::PixW-1:0]               i_pix,
    input  bb3_pkg::t_tag                          i_tag,
    output logic                                   o_v,
    output bb3_pkg::t_tag                          o_tag,
    output logic [2:0][bb3_pkg::SumW-1:0]          o_sum,
    output logic [bb3_pkg::PixW-1:0]               o_center,
    output bb3_pkg::t_inflight                     o_inflight
);

    localparam int ColW = $clog2(MAX_WIDTH);
    localparam int ChW  = bb3_pkg::ChW;

    logic [bb3_pkg::PixW-1:0] r_old_mem [MAX_WIDTH];
    logic [bb3_pkg::PixW-1:0] r_new_mem [MAX_WIDTH];

    logic [bb3_pkg::PixW-1:0] r_rd_old;
    logic [bb3_pkg::PixW-1:0] r_rd_new;
    logic                     r_fwd;
    logic [bb3_pkg::PixW-1:0] r_fwd_old;
    logic [bb3_pkg::PixW-1:0] r_fwd_new;

    logic                     r_v1;
    logic [ColW-1:0]          r_col1;
    logic [bb3_pkg::PixW-1:0] r_pix1;
    bb3_pkg::t_tag            r_tag1;

    logic [bb3_pkg::PixW-1:0] r_win [9];
    logic                     r_v2;
    bb3_pkg::t_tag            r_tag2;

    logic                          r_v3;
    bb3_pkg::t_tag                 r_tag3;
    logic [2:0][bb3_pkg::SumW-1:0] r_sum3;
    logic [bb3_pkg::PixW-1:0]      r_center3;

    logic [bb3_pkg::PixW-1:0]      eff_old;
    logic [bb3_pkg::PixW-1:0]      eff_new;
    logic [2:0][bb3_pkg::SumW-1:0] n_sum;

    always_ff @(posedge i_clk) begin
        r_rd_old <= r_old_mem[i_col];
        r_rd_new <= r_new_mem[i_col];
        if (r_v1) begin
            r_old_mem[r_col1] <= eff_new;
            r_new_mem[r_col1] <= r_pix1;
        end
    end

    // the entry written this cycle is read-old; bypass it
    assign eff_old = r_fwd ? r_fwd_old : r_rd_old;
    assign eff_new = r_fwd ? r_fwd_new : r_rd_new;

    always_ff @(posedge i_clk) begin
        r_fwd     <= r_v1 && (r_col1 == i_col);
        r_fwd_old <= eff_new;
        r_fwd_new <= r_pix1;
        r_col1    <= i_col;
        r_pix1    <= i_pix;
        r_tag1    <= i_tag;
        if (r_v1) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= eff_old;
            r_win[5] <= eff_new;
            r_win[8] <= r_pix1;
        end
        r_tag2    <= r_tag1;
        r_tag3    <= r_tag2;
        r_sum3    <= n_sum;
        r_center3 <= r_win[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_v;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = '0;
            for (int k = 0; k < 9; k++) begin
                n_sum[c] = n_sum[c] + bb3_pkg::SumW'(r_win[k][c*ChW +: ChW]);
            end
        end
    end

    assign o_v           = r_v3;
    assign o_tag         = r_tag3;
    assign o_sum         = r_sum3;
    assign o_center      = r_center3;
    assign o_inflight.s1 = r_v1 && r_tag1.emit;
    assign o_inflight.s2 = r_v2 && r_tag2.emit;
    assign o_inflight.s3 = r_v3 && r_tag3.emit;

endmodule

// ===== hw/rtl/bb3_outq.sv =====
module bb3_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_v,
    input  bb3_pkg::t_tag                 i_tag,
    input  logic [2:0][bb3_pkg::SumW-1:0] i_sum,
    input  logic [bb3_pkg::PixW-1:0]      i_center,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [bb3_pkg::PixW-1:0]      o_data,
    output logic                          o_last,
    output logic [bb3_pkg::OccW-1:0]      o_occ
);

    localparam int ChW   = bb3_pkg::ChW;
    localparam int ProdW = bb3_pkg::SumW + bb3_pkg::DivMulW;

    bb3_pkg::t_result         r_q_mem [bb3_pkg::OutDepth];
    logic [bb3_pkg::PtrW-1:0] r_wr;
    logic [bb3_pkg::PtrW-1:0] r_rd;
    logic [bb3_pkg::OccW-1:0] r_occ;

    logic [2:0][ProdW-1:0]    prod;
    bb3_pkg::t_result         n_res;
    logic                     push;
    logic                     pop;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = ProdW'(i_sum[c]) * ProdW'(bb3_pkg::DivMul);
            n_res.pix[c*ChW +: ChW] = i_tag.interior
                ? prod[c][bb3_pkg::DivShift +: ChW]
                : i_center[c*ChW +: ChW];
        end
        n_res.last = i_tag.last;
    end

    assign push = i_v && i_tag.emit;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mem[r_wr] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_occ <= '0;
        end else begin
            if (push) r_wr <= r_wr + bb3_pkg::PtrW'(1);
            if (pop)  r_rd <= r_rd + bb3_pkg::PtrW'(1);
            if (push && !pop) begin
                r_occ <= r_occ + bb3_pkg::OccW'(1);
            end else if (pop && !push) begin
                r_occ <= r_occ - bb3_pkg::OccW'(1);
            end
        end
    end

    assign o_valid = r_occ != '0;
    assign o_data  = r_q_mem[r_rd].pix;
    assign o_last  = r_q_mem[r_rd].last;
    assign o_occ   = r_occ;

endmodule

// ===== hw/rtl/box_blur_3x3_rgb_top.sv =====
// A result passes the window's read, window and sum registers and the output queue after the
//   request that completes its window; in stream terms each result trails its input by one row plus one pixel.
// Throughput: one request per cycle while the output queue has room, set by the single read and write port of
//   each line store; the input stalls once queued and in-flight results take all 8 queue slots.
// Reset (synchronous, active low): counters, pipeline and queue cleared, width 640,
//   height 480; line stores keep their contents and need no clearing pass.
module box_blur_3x3_rgb_top #(
    parameter int MAX_WIDTH = bb3_pkg::MaxWidthDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [bb3_pkg::CfgW-1:0] i_cfg_data,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [23:0]              i_s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                     i_s_axis_tuser,  // cmd
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [23:0]              o_m_axis_tdata,  // red_out, green_out, blue_out
    output logic                     o_m_axis_tlast   // frame_end
);

    localparam int ColW = $clog2(MAX_WIDTH);
    localparam int CntW = bb3_pkg::OccW + 1;

    logic                          acc;
    logic                          v0;
    logic [ColW-1:0]               col0;
    logic [bb3_pkg::PixW-1:0]      pix0;
    bb3_pkg::t_tag                 tag0;
    logic                          v3;
    bb3_pkg::t_tag                 tag3;
    logic [2:0][bb3_pkg::SumW-1:0] sum3;
    logic [bb3_pkg::PixW-1:0]      center3;
    bb3_pkg::t_inflight            inflight;
    logic [bb3_pkg::OccW-1:0]      occ;
    logic [CntW-1:0]               committed;

    // hold off requests while every queue slot is spoken for
    assign committed = CntW'(occ) + CntW'(inflight.s1) + CntW'(inflight.s2)
                       + CntW'(inflight.s3);
    assign o_s_axis_tready = committed < CntW'(bb3_pkg::OutDepth);
    assign acc = i_s_axis_tvalid && o_s_axis_tready;

    bb3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (bb3_pkg::t_cfg_idx'(i_cfg_idx)),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_cmd      (i_s_axis_tuser),
        .i_pix      (i_s_axis_tdata),
        .o_v        (v0),
        .o_col      (col0),
        .o_pix      (pix0),
        .o_tag      (tag0)
    );

    bb3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_v        (v0),
        .i_col      (col0),
        .i_pix      (pix0),
        .i_tag      (tag0),
        .o_v        (v3),
        .o_tag      (tag3),
        .o_sum      (sum3),
        .o_center   (center3),
        .o_inflight (inflight)
    );

    bb3_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_v      (v3),
        .i_tag    (tag3),
        .i_sum    (sum3),
        .i_center (center3),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_data   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast),
        .o_occ    (occ)
    );

endmodule

// ===== hw/rtl/bb3_checker.sv =====
`include "assert_macros.svh"

module bb3_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_axis_tvalid,
    input logic                     o_s_axis_tready,
    input logic                     o_m_axis_tvalid,
    input logic                     i_m_axis_tready,
    input logic [23:0]              o_m_axis_tdata,
    input logic                     o_m_axis_tlast
);

    // a result waiting on the sink holds its payload
    `BB3_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "output changed while stalled")

    // reset empties the result queue
    `BB3_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_axis_tvalid, "result left after reset")

    // reset leaves room for a request
    `BB3_ASSERT_ALWAYS(a_rst_ready, !i_rst_n |=> o_s_axis_tready, "not ready after reset")

    // a result showing up in an empty queue comes from an earlier accepted request
    `BB3_ASSERT(a_out_origin, $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready, 4), "result without request")

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (.*);
